>>> rtl/core/lbs_pkg.sv
// lbs_pkg: shared types and constants of the link bring-up sequencer
`default_nettype none

package lbs_pkg;

  localparam int unsigned CountdownWidth = 16;
  localparam int unsigned AddrWidth      = 3;
  localparam int unsigned DataWidth      = 32;

  localparam logic [CountdownWidth-1:0] RecoveryMsReset = 16'd1000;

  // register byte addresses
  localparam logic [AddrWidth-1:0] AddrRecoveryMs = 3'd0;

  typedef enum logic [3:0] {
    ST_BOOT      = 4'd0,
    ST_WAIT_HDMI = 4'd1,
    ST_SCAN      = 4'd2,
    ST_DISCOVER  = 4'd3,
    ST_ARC_INIT  = 4'd4,
    ST_QUERY     = 4'd5,
    ST_ATTACH    = 4'd6,
    ST_IDLE      = 4'd7,
    ST_STREAM    = 4'd8,
    ST_DETACH    = 4'd9,
    ST_RECOVERY  = 4'd10
  } fsm_state_t;

  typedef struct packed {
    logic ms_tick;
    logic recovery_request;
    logic hdmi_present;
    logic audio_sys_seen;
    logic arc_started;
    logic system_audio_enabled;
    logic usb_link_ok;
    logic usb_attached;
    logic usb_streaming;
  } item_t;

  typedef struct packed {
    logic [3:0] fsm_code;
    logic       attach_request;
    logic       state_changed;
  } result_t;

  typedef struct packed {
    fsm_state_t                fsm;
    logic                      attach;
    logic [CountdownWidth-1:0] countdown;
  } seq_state_t;

endpackage

`default_nettype wire

>>> rtl/core/lbs_step.sv
// lbs_step: one evaluation pass of the bring-up state machine
`default_nettype none

module lbs_step (
  input  var lbs_pkg::seq_state_t                    cur,
  input  var lbs_pkg::item_t                         item,
  input  var logic [lbs_pkg::CountdownWidth-1:0]     recovery_disconnect_ms,
  output lbs_pkg::seq_state_t                        nxt,
  output lbs_pkg::result_t                           word
);
  import lbs_pkg::*;

  logic [CountdownWidth-1:0] cd_ticked;
  fsm_state_t                s_pre;
  logic                      attach_pre;

  always_comb begin
    cd_ticked = cur.countdown;
    if (item.ms_tick && (cur.countdown != '0)) begin
      cd_ticked = cur.countdown - 1'b1;
    end

    s_pre      = cur.fsm;
    attach_pre = cur.attach;
    nxt.countdown = cd_ticked;
    if (item.recovery_request) begin
      attach_pre    = 1'b0;
      nxt.countdown = recovery_disconnect_ms;
      s_pre         = ST_RECOVERY;
    end

    // readiness loss forces detach before the state rules
    if (((s_pre == ST_ATTACH) || (s_pre == ST_IDLE) || (s_pre == ST_STREAM))
        && !item.usb_link_ok) begin
      s_pre = ST_DETACH;
    end

    nxt.fsm    = s_pre;
    nxt.attach = attach_pre;
    case (s_pre)
      ST_WAIT_HDMI: begin
        if (item.hdmi_present) nxt.fsm = ST_SCAN;
      end
      ST_SCAN: begin
        if (!item.hdmi_present) nxt.fsm = ST_WAIT_HDMI;
        else if (item.audio_sys_seen) nxt.fsm = ST_DISCOVER;
      end
      ST_DISCOVER: begin
        if (!item.hdmi_present) nxt.fsm = ST_WAIT_HDMI;
        else if (!item.audio_sys_seen) nxt.fsm = ST_SCAN;
        else if (item.system_audio_enabled || item.arc_started) nxt.fsm = ST_ARC_INIT;
      end
      ST_ARC_INIT: begin
        if (!item.hdmi_present) nxt.fsm = ST_WAIT_HDMI;
        else if (!item.audio_sys_seen) nxt.fsm = ST_SCAN;
        else if (item.arc_started) nxt.fsm = ST_QUERY;
      end
      ST_QUERY: begin
        if (!item.hdmi_present) nxt.fsm = ST_WAIT_HDMI;
        else if (item.usb_link_ok) nxt.fsm = ST_ATTACH;
        else if (!item.arc_started) nxt.fsm = ST_ARC_INIT;
      end
      ST_ATTACH: begin
        nxt.attach = 1'b1;
        if (item.usb_attached) nxt.fsm = ST_IDLE;
      end
      ST_IDLE: begin
        if (item.usb_streaming) nxt.fsm = ST_STREAM;
      end
      ST_STREAM: begin
        if (!item.usb_streaming) nxt.fsm = ST_IDLE;
      end
      ST_DETACH: begin
        nxt.attach = 1'b0;
        if (!item.usb_attached) begin
          if (!item.hdmi_present) nxt.fsm = ST_WAIT_HDMI;
          else if (!item.audio_sys_seen) nxt.fsm = ST_SCAN;
          else if (!item.arc_started) nxt.fsm = ST_ARC_INIT;
          else nxt.fsm = ST_QUERY;
        end
      end
      ST_RECOVERY: begin
        if ((nxt.countdown == '0) && !item.usb_attached) nxt.fsm = ST_QUERY;
      end
      default: begin
        // boot and unused codes
        nxt.fsm = ST_WAIT_HDMI;
      end
    endcase

    word.fsm_code       = nxt.fsm;
    word.attach_request = nxt.attach;
    word.state_changed  = (nxt.fsm != cur.fsm);
  end

endmodule

`default_nettype wire

>>> rtl/core/link_bringup_sequencer.sv
// link_bringup_sequencer: top level with result register, skid stage and config port
//
// each input word is one evaluation pass of the bring-up machine; it carries
// the link status flags and a one-millisecond tick. every input word yields
// exactly one result word: state code, attach request and a change pulse.
// input channel: item / item_valid / item_stall, accepted when valid and not
// stall. result channel: result / result_valid / result_stall, same rule.
// an accepted word's result is registered, in the skid while a result waits;
// throughput is one word per cycle while item_stall is low (single lbs_step pass).
// the result register is backed by a one-word skid stage, so a word is still
// accepted while a result waits; item_stall rises only once the skid is full
// and drops the cycle after the receiver takes a word.
// the APB port holds recovery_disconnect_ms at address 0; pready is always
// high and writes land on the access cycle.
// synchronous reset puts the machine in boot, clears the attach request and
// countdown, loads recovery_disconnect_ms with 1000 and empties both stages.
`default_nettype none

module link_bringup_sequencer (
  input  var logic                            clk,
  input  var logic                            rst,
  input  var lbs_pkg::item_t                  item,
  input  var logic                            item_valid,
  output logic                                item_stall,
  output lbs_pkg::result_t                    result,
  output logic                                result_valid,
  input  var logic                            result_stall,
  input  var logic                            psel,
  input  var logic                            penable,
  input  var logic                            pwrite,
  input  var logic [lbs_pkg::AddrWidth-1:0]   paddr,
  input  var logic [lbs_pkg::DataWidth-1:0]   pwdata,
  output logic [lbs_pkg::DataWidth-1:0]       prdata,
  output logic                                pready
);
  import lbs_pkg::*;

  logic [CountdownWidth-1:0] recovery_disconnect_ms;
  seq_state_t                cur;
  seq_state_t                cur_next;
  result_t                   word;
  result_t                   skid;
  logic                      skid_valid;
  logic                      accept;
  logic                      take;
  logic                      cfg_write;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && (paddr == AddrRecoveryMs);
  assign prdata     = (paddr == AddrRecoveryMs)
                    ? {{(DataWidth-CountdownWidth){1'b0}}, recovery_disconnect_ms} : '0;

  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign take       = result_valid && !result_stall;

  lbs_step u_step (
    .cur                    (cur),
    .item                   (item),
    .recovery_disconnect_ms (recovery_disconnect_ms),
    .nxt                    (cur_next),
    .word                   (word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      recovery_disconnect_ms <= RecoveryMsReset;
      cur.fsm                <= ST_BOOT;
      cur.attach             <= 1'b0;
      cur.countdown          <= '0;
      result_valid           <= 1'b0;
      skid_valid             <= 1'b0;
    end else begin
      if (cfg_write) begin
        recovery_disconnect_ms <= pwdata[CountdownWidth-1:0];
      end
      if (accept) begin
        cur <= cur_next;
      end
      if (accept && result_valid && result_stall) begin
        skid_valid <= 1'b1;
      end else if (accept) begin
        result_valid <= 1'b1;
      end else if (take && skid_valid) begin
        skid_valid <= 1'b0;
      end else if (take) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload side of the result register and skid
  always_ff @(posedge clk) begin
    if (accept && result_valid && result_stall) begin
      skid <= word;
    end else if (accept) begin
      result <= word;
    end else if (take && skid_valid) begin
      result <= skid;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lbs_checker.sv
// lbs_checker: port-level assertions for the link bring-up sequencer, with bind
`default_nettype none

module lbs_checker (
  input var logic             clk,
  input var logic             rst,
  input var logic             item_stall,
  input var lbs_pkg::result_t result,
  input var logic             result_valid,
  input var logic             result_stall
);
  import lbs_pkg::*;

  logic [3:0] prev_code;

  // state code of the last delivered word, boot after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_code <= ST_BOOT;
    end else if (result_valid && !result_stall) begin
      prev_code <= result.fsm_code;
    end
  end

  a_changed_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.state_changed == (result.fsm_code != prev_code)))
    else $error("state_changed disagrees with consecutive state codes");

  a_attach_states: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.attach_request) |->
      ((result.fsm_code == ST_ATTACH) || (result.fsm_code == ST_IDLE) ||
       (result.fsm_code == ST_STREAM)))
    else $error("attach request held outside attach, idle or streaming");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !item_stall))
    else $error("stages not empty after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result word changed");

endmodule

bind link_bringup_sequencer lbs_checker u_lbs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result       (result),
  .result_valid (result_valid),
  .result_stall (result_stall)
);

`default_nettype wire
